// ----- hw/rtl/keyword_substitution_cipher_top_defines.svh -----
// assertion macros for the keyword substitution cipher rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KWS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define KWS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define KWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define KWS_ASSERT_ALWAYS(label, clk, rst, expr)
`define KWS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define KWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/kwsub_pkg.sv -----
// types and constants of the keyword substitution cipher
// no dependencies
package kwsub_pkg;

   localparam int ALPHA_SIZE = 26;
   localparam int IDX_W      = 5;

   localparam logic [7:0] CHAR_A  = 8'h41;
   localparam logic [7:0] CHAR_Z  = 8'h5a;
   localparam logic [7:0] CHAR_LA = 8'h61;
   localparam logic [7:0] CHAR_LZ = 8'h7a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [2:0] OP_KEY    = 3'd0;
   localparam logic [2:0] OP_FINAL  = 3'd1;
   localparam logic [2:0] OP_ENC    = 3'd2;
   localparam logic [2:0] OP_DEC    = 3'd3;
   localparam logic [2:0] OP_BEGIN  = 3'd4;

   localparam logic [2:0] STAT_DATA       = 3'd0;
   localparam logic [2:0] STAT_TAKEN      = 3'd1;
   localparam logic [2:0] STAT_IGNORED    = 3'd2;
   localparam logic [2:0] STAT_DONE       = 3'd3;
   localparam logic [2:0] STAT_INCOMPLETE = 3'd4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic             clear;
      logic             place;
      logic [IDX_W-1:0] idx;
   } store_cmd_type;

endpackage

// ----- hw/rtl/kwsub_store.sv -----
// alphabet store: forward and inverse tables, used letters, fill position
// depends on kwsub_pkg and keyword_substitution_cipher_top_defines.svh
`include "keyword_substitution_cipher_top_defines.svh"

module kwsub_store
   import kwsub_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  store_cmd_type         cmd,
   input  logic [IDX_W-1:0]      rd_idx,
   output logic [IDX_W-1:0]      fwd_data,
   output logic [IDX_W-1:0]      inv_data,
   output logic [ALPHA_SIZE-1:0] used
);

   logic [IDX_W-1:0]      fwd_ff  [ALPHA_SIZE];
   logic [IDX_W-1:0]      fwd_in  [ALPHA_SIZE];
   logic [IDX_W-1:0]      inv_ff  [ALPHA_SIZE];
   logic [IDX_W-1:0]      inv_in  [ALPHA_SIZE];
   logic [ALPHA_SIZE-1:0] used_ff;
   logic [ALPHA_SIZE-1:0] used_in;
   logic [IDX_W-1:0]      fill_ff;
   logic [IDX_W-1:0]      fill_in;

   always_comb begin
      fwd_in  = fwd_ff;
      inv_in  = inv_ff;
      used_in = used_ff;
      fill_in = fill_ff;
      if (cmd.clear) begin
         for (int i = 0; i < ALPHA_SIZE; i++) begin
            fwd_in[i] = IDX_W'(i);
            inv_in[i] = IDX_W'(i);
         end
         used_in = '0;
         fill_in = '0;
      end else if (cmd.place) begin
         if (fill_ff < IDX_W'(ALPHA_SIZE)) begin
            fwd_in[fill_ff] = cmd.idx;
            inv_in[cmd.idx] = fill_ff;
            fill_in         = fill_ff + IDX_W'(1);
         end
         used_in[cmd.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHA_SIZE; i++) begin
            fwd_ff[i] <= IDX_W'(i);
            inv_ff[i] <= IDX_W'(i);
         end
         used_ff <= '0;
         fill_ff <= '0;
      end else begin
         fwd_ff  <= fwd_in;
         inv_ff  <= inv_in;
         used_ff <= used_in;
         fill_ff <= fill_in;
      end
   end

   assign fwd_data = fwd_ff[rd_idx];
   assign inv_data = inv_ff[rd_idx];
   assign used     = used_ff;

   `KWS_ASSERT_ALWAYS(a_fill_matches_used, clock, reset,
      fill_ff == IDX_W'($countones(used_ff)))
   `KWS_ASSERT_IMPL(a_no_duplicate_place, clock, reset,
      cmd.place && !cmd.clear, !used_ff[cmd.idx])
   `KWS_ASSERT_NEXT(a_clear_empties, clock, reset,
      cmd.clear, fill_ff == '0 && used_ff == '0)

endmodule

// ----- hw/rtl/keyword_substitution_cipher_top.sv -----
// keyword substitution cipher: command sequencer, finalize scan, result register
// depends on kwsub_pkg, kwsub_store and keyword_substitution_cipher_top_defines.svh
//
// usage
//   a request (req_data: opcode, in_byte) transfers at a rising edge with start high
//   and busy low. every request gives exactly one result on rsp_data, shown for
//   one cycle with rsp_valid high; the receiver cannot hold it off.
//   keyword, encrypt, decrypt, begin and unknown opcodes: the request is taken,
//   executed in S_EXEC with one table lookup, and the result is registered and
//   shown when busy is low again; the next request can be taken while it shows.
//   finalize while a key is being built scans the 26 letters, one per cycle,
//   through the shared placement port of the store; the result is shown when the
//   scan ends and busy is low again. finalize on a ready key does not scan.
//   reset (synchronous, active high) loads identity tables, clears the used
//   letters and the fill position, and marks the key ready; busy and rsp_valid
//   are low after it.
`include "keyword_substitution_cipher_top_defines.svh"

module keyword_substitution_cipher_top
   import kwsub_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   logic [2:0]            op_ff;
   logic [2:0]            op_in;
   logic [7:0]            byte_ff;
   logic [7:0]            byte_in;
   logic                  key_ready_ff;
   logic                  key_ready_in;
   logic [IDX_W-1:0]      scan_ff;
   logic [IDX_W-1:0]      scan_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   store_cmd_type         cmd;
   logic [IDX_W-1:0]      fwd_data;
   logic [IDX_W-1:0]      inv_data;
   logic [ALPHA_SIZE-1:0] used;
   logic                  is_letter;
   logic [IDX_W-1:0]      idx;
   logic [7:0]            req_up;

   kwsub_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_idx   (idx),
      .fwd_data (fwd_data),
      .inv_data (inv_data),
      .used     (used)
   );

   // upper-case on the way in
   always_comb begin
      req_up = req_data.in_byte;
      if (req_data.in_byte >= CHAR_LA && req_data.in_byte <= CHAR_LZ) begin
         req_up = req_data.in_byte - CASE_OFFSET;
      end
   end

   assign is_letter = (byte_ff >= CHAR_A) && (byte_ff <= CHAR_Z);
   assign idx       = IDX_W'(byte_ff - CHAR_A);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      byte_in      = byte_ff;
      key_ready_in = key_ready_ff;
      scan_in      = scan_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.opcode;
               byte_in  = req_up;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in        = S_IDLE;
            rsp_valid_in    = 1'b1;
            rsp_in.out_byte = '0;
            rsp_in.status   = STAT_DATA;
            unique case (op_ff)
               OP_KEY: begin
                  rsp_in.status = STAT_IGNORED;
                  if (!key_ready_ff && is_letter && !used[idx]) begin
                     cmd.place       = 1'b1;
                     cmd.idx         = idx;
                     rsp_in.out_byte = byte_ff;
                     rsp_in.status   = STAT_TAKEN;
                  end
               end
               OP_FINAL: begin
                  rsp_in.status = STAT_DONE;
                  if (!key_ready_ff) begin
                     rsp_valid_in = 1'b0;
                     scan_in      = '0;
                     state_in     = S_SCAN;
                  end
               end
               OP_ENC, OP_DEC: begin
                  if (!key_ready_ff) begin
                     rsp_in.status = STAT_INCOMPLETE;
                  end else if (is_letter) begin
                     rsp_in.out_byte = CHAR_A +
                        8'((op_ff == OP_ENC) ? fwd_data : inv_data);
                  end else begin
                     rsp_in.out_byte = byte_ff;
                  end
               end
               OP_BEGIN: begin
                  cmd.clear     = 1'b1;
                  key_ready_in  = 1'b0;
                  rsp_in.status = STAT_INCOMPLETE;
               end
               default: begin
                  rsp_in.status = STAT_DATA;
               end
            endcase
         end
         S_SCAN: begin
            cmd.place = !used[scan_ff];
            cmd.idx   = scan_ff;
            if (scan_ff == IDX_W'(ALPHA_SIZE - 1)) begin
               key_ready_in    = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_in.out_byte = '0;
               rsp_in.status   = STAT_DONE;
               state_in        = S_IDLE;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         key_ready_ff <= key_ready_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
      end
      op_ff   <= op_in;
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `KWS_ASSERT_IMPL(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   `KWS_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, state_ff == S_EXEC)
   `KWS_ASSERT_IMPL(a_scan_only_building, clock, reset,
      state_ff == S_SCAN, !key_ready_ff && scan_ff < IDX_W'(ALPHA_SIZE))
   `KWS_ASSERT_NEXT(a_scan_end_ready, clock, reset,
      state_ff == S_SCAN && scan_ff == IDX_W'(ALPHA_SIZE - 1),
      key_ready_ff && rsp_valid_ff && rsp_ff.status == STAT_DONE)

endmodule
